// File: rtl/dpf_pkg.sv
// dpf_pkg: types, widths and helpers shared by the deep pixel flatten block
// depends on nothing; compiled first

package dpf_pkg;

   // field and datapath widths (fixed by the signed q16.16 data words)
   localparam int DPF_DATA_W   = 32;
   localparam int DPF_SUM_W    = DPF_DATA_W + 2;   // sum of three alphas
   localparam int DPF_MAG_W    = DPF_DATA_W + 1;   // magnitude of that sum
   localparam int DPF_FACTOR_W = DPF_DATA_W + 1;   // one minus a q value
   localparam int DPF_PROD_W   = DPF_FACTOR_W + DPF_DATA_W;
   localparam int DPF_SPROD_W  = 2 * DPF_DATA_W;
   localparam int DPF_WIDE_W   = DPF_PROD_W + 1;

   localparam int DPF_FRAC_BITS = 16;

   // lane layout: colours, then alphas, then the two depths
   localparam int DPF_CHANNELS = 3;
   localparam int DPF_DEPTHS   = 2;
   localparam int DPF_LANES    = 2 * DPF_CHANNELS + DPF_DEPTHS;

   // divide by three: mag = hi * 2^17 + lo, 2^17 = 3 * 43690 + 2
   localparam int DPF_LO_W  = 17;
   localparam int DPF_HI_W  = DPF_MAG_W - DPF_LO_W;
   localparam int DPF_REM_W = DPF_LO_W + 1;
   localparam int DPF_QHI_W = 2 * DPF_HI_W;
   localparam int DPF_DIV3_SHIFT = DPF_REM_W + 1;
   localparam int DPF_QLO_W = 2 * DPF_REM_W - DPF_DIV3_SHIFT;
   localparam logic [DPF_HI_W-1:0]  DPF_DIV3_HI    = 16'd43690;
   localparam logic [DPF_REM_W-1:0] DPF_DIV3_RECIP = 18'd174763;

   localparam logic signed [DPF_DATA_W-1:0] DPF_Q_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [DPF_DATA_W-1:0] DPF_Q_MIN = 32'sh8000_0000;

   typedef struct packed {
      logic signed [DPF_DATA_W-1:0] red;
      logic signed [DPF_DATA_W-1:0] green;
      logic signed [DPF_DATA_W-1:0] blue;
      logic signed [DPF_DATA_W-1:0] alpha_red;
      logic signed [DPF_DATA_W-1:0] alpha_green;
      logic signed [DPF_DATA_W-1:0] alpha_blue;
      logic signed [DPF_DATA_W-1:0] depth_front;
      logic signed [DPF_DATA_W-1:0] depth_back;
      logic                         last_sample;
      logic                         empty_pixel;
   } req_word_type;

   typedef struct packed {
      logic signed [DPF_DATA_W-1:0] out_red;
      logic signed [DPF_DATA_W-1:0] out_green;
      logic signed [DPF_DATA_W-1:0] out_blue;
      logic signed [DPF_DATA_W-1:0] out_alpha_red;
      logic signed [DPF_DATA_W-1:0] out_alpha_green;
      logic signed [DPF_DATA_W-1:0] out_alpha_blue;
      logic signed [DPF_DATA_W-1:0] out_depth_front;
      logic signed [DPF_DATA_W-1:0] out_depth_back;
   } rsp_word_type;

   // step strobes from the sequencer to the mean unit and the lanes
   typedef struct packed {
      logic sum_en;
      logic div_en;
      logic mean_en;
      logic prod_en;
      logic commit_en;
      logic clear_en;
   } dpf_step_type;

   // clamp a wide signed value to the 32-bit signed range
   function automatic logic signed [DPF_DATA_W-1:0] dpf_sat(
      input logic signed [DPF_WIDE_W-1:0] v);
      if (v > DPF_WIDE_W'(DPF_Q_MAX)) begin
         return DPF_Q_MAX;
      end else if (v < DPF_WIDE_W'(DPF_Q_MIN)) begin
         return DPF_Q_MIN;
      end
      return v[DPF_DATA_W-1:0];
   endfunction

endpackage

// File: rtl/dpf_if.sv
// dpf_req_if and dpf_rsp_if: valid/ready channels carrying sample and pixel words
// depends on dpf_pkg

interface dpf_req_if import dpf_pkg::*; ();
   logic         valid;
   logic         ready;
   req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface dpf_rsp_if import dpf_pkg::*; ();
   logic         valid;
   logic         ready;
   rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// File: rtl/dpf_lane.sv
// dpf_lane: one channel's multiply-accumulate with truncation and saturation
// depends on dpf_pkg

module dpf_lane import dpf_pkg::*; #(
   parameter int FRAC_BITS = DPF_FRAC_BITS,
   parameter bit SCALED    = 1'b0
) (
   input  logic                           clock,
   input  logic                           reset,
   input  dpf_step_type                   step,
   input  logic signed [DPF_FACTOR_W-1:0] factor,
   input  logic signed [DPF_DATA_W-1:0]   value,
   input  logic signed [DPF_DATA_W-1:0]   mean,
   output logic signed [DPF_DATA_W-1:0]   acc,
   output logic signed [DPF_DATA_W-1:0]   acc_after
);

   localparam logic signed [DPF_PROD_W-1:0] PROD_BIAS =
      (DPF_PROD_W'(1) <<< FRAC_BITS) - DPF_PROD_W'(1);

   logic signed [DPF_DATA_W-1:0] acc_ff;
   logic signed [DPF_DATA_W-1:0] acc_next;
   logic signed [DPF_DATA_W-1:0] base;
   logic signed [DPF_PROD_W-1:0] prod_ff;
   logic signed [DPF_PROD_W-1:0] prod_in;
   logic signed [DPF_PROD_W-1:0] prod_adj;
   logic signed [DPF_PROD_W-1:0] prod_q;

   assign prod_in = factor * value;

   // divide by 2^frac with truncation toward zero
   always_comb begin
      prod_adj = prod_ff + (prod_ff[DPF_PROD_W-1] ? PROD_BIAS : '0);
      prod_q   = prod_adj >>> FRAC_BITS;
      acc_next = dpf_sat(DPF_WIDE_W'(base) + DPF_WIDE_W'(prod_q));
   end

   if (SCALED) begin : g_scaled
      localparam logic signed [DPF_SPROD_W-1:0] SPROD_BIAS =
         (DPF_SPROD_W'(1) <<< FRAC_BITS) - DPF_SPROD_W'(1);

      logic signed [DPF_SPROD_W-1:0] sprod_ff;
      logic signed [DPF_SPROD_W-1:0] sprod_adj;
      logic signed [DPF_SPROD_W-1:0] sprod_q;

      // depth is first rescaled by the mean coverage
      always_ff @(posedge clock) begin
         if (step.prod_en) begin
            sprod_ff <= acc_ff * mean;
         end
      end

      always_comb begin
         sprod_adj = sprod_ff + (sprod_ff[DPF_SPROD_W-1] ? SPROD_BIAS : '0);
         sprod_q   = sprod_adj >>> FRAC_BITS;
         base      = dpf_sat(DPF_WIDE_W'(sprod_q));
      end
   end else begin : g_plain
      assign base = acc_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (step.clear_en) begin
         acc_ff <= '0;
      end else if (step.commit_en) begin
         acc_ff <= acc_next;
      end
      if (step.prod_en) begin
         prod_ff <= prod_in;
      end
   end

   assign acc       = acc_ff;
   assign acc_after = step.commit_en ? acc_next : acc_ff;

endmodule

// File: rtl/dpf_mean.sv
// dpf_mean: merges the alpha lanes into the mean coverage and blend factors
// depends on dpf_pkg; driven by the step strobes of deep_pixel_flatten

module dpf_mean import dpf_pkg::*; #(
   parameter int FRAC_BITS = DPF_FRAC_BITS
) (
   input  logic                           clock,
   input  dpf_step_type                   step,
   input  logic signed [DPF_DATA_W-1:0]   alpha_acc [DPF_CHANNELS],
   output logic signed [DPF_DATA_W-1:0]   mean,
   output logic signed [DPF_FACTOR_W-1:0] one_minus_mean,
   output logic signed [DPF_FACTOR_W-1:0] one_minus_own [DPF_CHANNELS],
   output logic                           opaque
);

   localparam logic signed [DPF_FACTOR_W-1:0] ONE = DPF_FACTOR_W'(1) <<< FRAC_BITS;
   localparam logic [DPF_MAG_W-1:0] ONE_MAG = DPF_MAG_W'(1) << FRAC_BITS;

   logic signed [DPF_SUM_W-1:0]    sum;
   logic signed [DPF_SUM_W-1:0]    neg_sum;
   logic                           neg_in;
   logic                           neg_ff;
   logic [DPF_MAG_W-1:0]           mag_in;
   logic [DPF_MAG_W-1:0]           mag_ff;
   logic [DPF_HI_W-1:0]            hi;
   logic [DPF_LO_W-1:0]            lo;
   logic [DPF_REM_W-1:0]           rem_sum;
   logic [2*DPF_REM_W-1:0]         rem_prod;
   logic [DPF_QHI_W-1:0]           qhi_in;
   logic [DPF_QHI_W-1:0]           qhi_ff;
   logic [DPF_QLO_W-1:0]           qlo_in;
   logic [DPF_QLO_W-1:0]           qlo_ff;
   logic [DPF_MAG_W-1:0]           quot;
   logic [DPF_MAG_W-1:0]           neg_quot;
   logic [DPF_MAG_W-1:0]           mean_wide;
   logic signed [DPF_DATA_W-1:0]   mean_in;
   logic signed [DPF_DATA_W-1:0]   mean_ff;
   logic signed [DPF_FACTOR_W-1:0] omm_in;
   logic signed [DPF_FACTOR_W-1:0] omm_ff;
   logic signed [DPF_FACTOR_W-1:0] own_in [DPF_CHANNELS];
   logic signed [DPF_FACTOR_W-1:0] own_ff [DPF_CHANNELS];
   logic                           opaque_in;
   logic                           opaque_ff;

   // sum of the alphas, split into sign and magnitude
   always_comb begin
      sum = DPF_SUM_W'(alpha_acc[0]) + DPF_SUM_W'(alpha_acc[1])
          + DPF_SUM_W'(alpha_acc[2]);
      neg_sum = -sum;
      neg_in  = sum[DPF_SUM_W-1];
      mag_in  = neg_in ? neg_sum[DPF_MAG_W-1:0] : sum[DPF_MAG_W-1:0];
   end

   // magnitude / 3 as hi * 43690 + (2 * hi + lo) / 3, the latter by reciprocal
   always_comb begin
      hi       = mag_ff[DPF_MAG_W-1:DPF_LO_W];
      lo       = mag_ff[DPF_LO_W-1:0];
      rem_sum  = {1'b0, hi, 1'b0} + DPF_REM_W'(lo);
      rem_prod = rem_sum * DPF_DIV3_RECIP;
      qhi_in   = hi * DPF_DIV3_HI;
      qlo_in   = rem_prod[2*DPF_REM_W-1:DPF_DIV3_SHIFT];
   end

   // quotient back to a signed mean, truncated toward zero
   always_comb begin
      quot      = DPF_MAG_W'(qhi_ff) + DPF_MAG_W'(qlo_ff);
      neg_quot  = -quot;
      mean_wide = neg_ff ? neg_quot : quot;
      mean_in   = mean_wide[DPF_DATA_W-1:0];
      omm_in    = ONE - DPF_FACTOR_W'(mean_in);
      opaque_in = !neg_ff && (quot >= ONE_MAG);
      for (int i = 0; i < DPF_CHANNELS; i++) begin
         own_in[i] = ONE - DPF_FACTOR_W'(alpha_acc[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (step.sum_en) begin
         neg_ff <= neg_in;
         mag_ff <= mag_in;
      end
      if (step.div_en) begin
         qhi_ff <= qhi_in;
         qlo_ff <= qlo_in;
      end
      if (step.mean_en) begin
         mean_ff   <= mean_in;
         omm_ff    <= omm_in;
         opaque_ff <= opaque_in;
         own_ff    <= own_in;
      end
   end

   assign mean           = mean_ff;
   assign one_minus_mean = omm_ff;
   assign one_minus_own  = own_ff;
   assign opaque         = opaque_ff;

endmodule

// File: rtl/deep_pixel_flatten.sv
// deep_pixel_flatten: front-to-back over compositing of one deep pixel
// depends on dpf_pkg, dpf_if, dpf_lane and dpf_mean

// The samples of a deep pixel arrive one word at a time, sorted front to back, and the
// flattened pixel leaves as one word when the sample marked last has been folded in (or at
// once for a word marked as an empty pixel). All data is signed with FRAC_BITS fraction bits;
// products truncate toward zero and every sum saturates. Eight lanes, one per colour, alpha
// and depth channel, each hold their accumulator and do their multiply-accumulate side by
// side; a mean unit merges the three alpha lanes into the mean coverage that scales the next
// sample, so one sample is in work at a time: it passes the sum of alphas, two steps of
// divide by three, products and accumulate, and the next one starts in the cycle after its
// accumulate; an empty pixel word goes straight to the accumulate step. A one-word input
// register takes the next sample while one is in work, and a one-word output register holds
// a finished pixel until taken, so neither side waits on the other unless both are full.

module deep_pixel_flatten import dpf_pkg::*; #(
   parameter int FRAC_BITS = DPF_FRAC_BITS
) (
   input logic        clock,
   input logic        reset,
   dpf_req_if.sink    req_if,
   dpf_rsp_if.source  rsp_if
);

   typedef enum logic [2:0] {
      PH_IDLE,
      PH_SUM,
      PH_DIV,
      PH_MEAN,
      PH_PROD,
      PH_UPDATE
   } phase_type;

   phase_type    phase_ff, phase_in;
   logic         in_vld_ff, in_vld_in;
   req_word_type in_word_ff, in_word_in;
   req_word_type work_ff, work_in;
   logic         out_vld_ff, out_vld_in;
   rsp_word_type out_word_ff, out_word_in;

   logic         emit;
   logic         out_free;
   logic         upd_done;
   logic         launch;
   logic         accept;
   dpf_step_type step;

   logic signed [DPF_DATA_W-1:0]   lane_value  [DPF_LANES];
   logic signed [DPF_FACTOR_W-1:0] lane_factor [DPF_LANES];
   logic signed [DPF_DATA_W-1:0]   lane_acc    [DPF_LANES];
   logic signed [DPF_DATA_W-1:0]   lane_after  [DPF_LANES];
   logic signed [DPF_DATA_W-1:0]   alpha_acc   [DPF_CHANNELS];
   logic signed [DPF_DATA_W-1:0]   mean;
   logic signed [DPF_FACTOR_W-1:0] one_minus_mean;
   logic signed [DPF_FACTOR_W-1:0] one_minus_own [DPF_CHANNELS];
   logic                           opaque;

   // handshake and sequencing
   always_comb begin
      emit     = work_ff.last_sample | work_ff.empty_pixel;
      out_free = !out_vld_ff || rsp_if.ready;
      // the update step waits only when it has a pixel to hand over and the output is full
      upd_done = (phase_ff == PH_UPDATE) && (!emit || out_free);
      launch   = in_vld_ff && ((phase_ff == PH_IDLE) || upd_done);
      accept   = req_if.valid && req_if.ready;
   end

   assign req_if.ready = !in_vld_ff || launch;

   // step strobes for the mean unit and the lanes
   always_comb begin
      step.sum_en    = (phase_ff == PH_SUM);
      step.div_en    = (phase_ff == PH_DIV);
      step.mean_en   = (phase_ff == PH_MEAN);
      step.prod_en   = (phase_ff == PH_PROD);
      // an opaque pixel ignores further samples but still hands over on its last one
      step.commit_en = upd_done && !work_ff.empty_pixel && !opaque;
      step.clear_en  = upd_done && emit;
   end

   always_comb begin
      phase_in   = phase_ff;
      in_vld_in  = in_vld_ff;
      in_word_in = in_word_ff;
      work_in    = work_ff;
      out_vld_in = out_vld_ff;
      out_word_in = out_word_ff;

      // input register
      if (accept) begin
         in_vld_in  = 1'b1;
         in_word_in = req_if.data;
      end else if (launch) begin
         in_vld_in = 1'b0;
      end

      if (launch) begin
         work_in = in_word_ff;
      end

      unique case (phase_ff)
         PH_IDLE: begin
            if (launch) begin
               phase_in = in_word_ff.empty_pixel ? PH_UPDATE : PH_SUM;
            end
         end
         PH_SUM:  phase_in = PH_DIV;
         PH_DIV:  phase_in = PH_MEAN;
         PH_MEAN: phase_in = PH_PROD;
         PH_PROD: phase_in = PH_UPDATE;
         PH_UPDATE: begin
            if (launch) begin
               phase_in = in_word_ff.empty_pixel ? PH_UPDATE : PH_SUM;
            end else if (upd_done) begin
               phase_in = PH_IDLE;
            end
         end
         default: phase_in = PH_IDLE;
      endcase

      // output register
      if (upd_done && emit) begin
         out_vld_in = 1'b1;
         if (work_ff.empty_pixel) begin
            // empty pixel: nothing covered, depths pushed to far
            out_word_in                 = '0;
            out_word_in.out_depth_front = DPF_Q_MAX;
            out_word_in.out_depth_back  = DPF_Q_MAX;
         end else begin
            out_word_in.out_red         = lane_after[0];
            out_word_in.out_green       = lane_after[1];
            out_word_in.out_blue        = lane_after[2];
            out_word_in.out_alpha_red   = lane_after[3];
            out_word_in.out_alpha_green = lane_after[4];
            out_word_in.out_alpha_blue  = lane_after[5];
            out_word_in.out_depth_front = lane_after[6];
            out_word_in.out_depth_back  = lane_after[7];
         end
      end else if (rsp_if.ready) begin
         out_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_IDLE;
         in_vld_ff  <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         phase_ff   <= phase_in;
         in_vld_ff  <= in_vld_in;
         out_vld_ff <= out_vld_in;
      end
      in_word_ff  <= in_word_in;
      work_ff     <= work_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_if.valid = out_vld_ff;
   assign rsp_if.data  = out_word_ff;

   // lane inputs: colours blend by their own alpha, the rest by the mean coverage
   always_comb begin
      lane_value[0] = work_ff.red;
      lane_value[1] = work_ff.green;
      lane_value[2] = work_ff.blue;
      lane_value[3] = work_ff.alpha_red;
      lane_value[4] = work_ff.alpha_green;
      lane_value[5] = work_ff.alpha_blue;
      lane_value[6] = work_ff.depth_front;
      lane_value[7] = work_ff.depth_back;
      for (int i = 0; i < DPF_LANES; i++) begin
         lane_factor[i] = (i < DPF_CHANNELS) ? one_minus_own[i % DPF_CHANNELS]
                                             : one_minus_mean;
      end
      for (int i = 0; i < DPF_CHANNELS; i++) begin
         alpha_acc[i] = lane_acc[DPF_CHANNELS + i];
      end
   end

   for (genvar g = 0; g < DPF_LANES; g++) begin : g_lane
      dpf_lane #(
         .FRAC_BITS (FRAC_BITS),
         .SCALED    (g >= 2 * DPF_CHANNELS)
      ) u_lane (
         .clock     (clock),
         .reset     (reset),
         .step      (step),
         .factor    (lane_factor[g]),
         .value     (lane_value[g]),
         .mean      (mean),
         .acc       (lane_acc[g]),
         .acc_after (lane_after[g])
      );
   end

   dpf_mean #(
      .FRAC_BITS (FRAC_BITS)
   ) u_mean (
      .clock          (clock),
      .step           (step),
      .alpha_acc      (alpha_acc),
      .mean           (mean),
      .one_minus_mean (one_minus_mean),
      .one_minus_own  (one_minus_own),
      .opaque         (opaque)
   );

endmodule

// File: rtl/dpf_checker.sv
// dpf_checker: port-level checks on deep_pixel_flatten, attached by bind
// depends on dpf_pkg and deep_pixel_flatten

module dpf_checker import dpf_pkg::*; (
   input logic         clock,
   input logic         reset,
   input logic         req_valid,
   input logic         req_ready,
   input logic         req_last,
   input logic         req_empty,
   input logic         rsp_valid,
   input logic         rsp_ready,
   input rsp_word_type rsp_data
);

   localparam logic [2:0] PENDING_MAX = 3'd3;

   logic [2:0] pending_ff, pending_in;
   logic       inc;
   logic       dec;

   // pixels owed: words that close a pixel, less words handed over
   always_comb begin
      inc        = req_valid && req_ready && (req_last || req_empty);
      dec        = rsp_valid && rsp_ready;
      pending_in = pending_ff + 3'(inc) - 3'(dec);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_in;
      end
   end

   a_reset_clean: assert property (@(posedge clock)
      reset |=> req_ready && !rsp_valid)
      else $error("not ready or result pending after reset");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> pending_ff != 3'd0)
      else $error("pixel word offered with no closing sample taken");

   a_bounded: assert property (@(posedge clock) disable iff (reset)
      pending_ff <= PENDING_MAX)
      else $error("more pixels owed than the block can hold");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("stalled pixel word changed or dropped");

endmodule

bind deep_pixel_flatten dpf_checker u_dpf_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_if.valid),
   .req_ready (req_if.ready),
   .req_last  (req_if.data.last_sample),
   .req_empty (req_if.data.empty_pixel),
   .rsp_valid (rsp_if.valid),
   .rsp_ready (rsp_if.ready),
   .rsp_data  (rsp_if.data)
);

// File: tb/deep_pixel_flatten_tb.sv
`timescale 1ns / 100ps
// deep_pixel_flatten_tb: self-checking bench for the deep pixel flatten block
// depends on dpf_pkg, dpf_req_if, dpf_rsp_if and the deep_pixel_flatten rtl

module deep_pixel_flatten_tb import dpf_pkg::*; ();

   localparam int CLOCK_PERIOD   = 8;
   localparam int RESET_CYCLES   = 12;
   localparam int RANDOM_WORDS   = 1450;
   // generous next to the time a sample takes through the block
   localparam int DRAIN_CYCLES   = 24;
   // cycles with no word moving on either side before we give up
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int UNIT_Q         = 1 << DPF_FRAC_BITS;

   typedef bit signed [DPF_DATA_W-1:0] q_value_type;

   // ------------------------------------------------------------------
   // scoreboard: running copy of the accumulators plus a queue of the
   // flattened pixels still owed by the block
   // ------------------------------------------------------------------
   class pixel_scoreboard_type;
      q_value_type  colour_acc[DPF_CHANNELS];
      q_value_type  alpha_acc[DPF_CHANNELS];
      q_value_type  depth_acc[DPF_DEPTHS];
      rsp_word_type owed_pixels[$];
      int           failures;

      function q_value_type clamp(longint v);
         if (v > longint'(DPF_Q_MAX)) return DPF_Q_MAX;
         if (v < longint'(DPF_Q_MIN)) return DPF_Q_MIN;
         return q_value_type'(v);
      endfunction

      // product back to q format, truncated toward zero
      function longint rescale(longint p);
         return p / (longint'(1) << DPF_FRAC_BITS);
      endfunction

      function void clear_pixel();
         foreach (colour_acc[i]) colour_acc[i] = '0;
         foreach (alpha_acc[i]) alpha_acc[i] = '0;
         foreach (depth_acc[i]) depth_acc[i] = '0;
      endfunction

      function int pending();
         return owed_pixels.size();
      endfunction

      // fold one accepted sample word into the running pixel
      function void note_sample(req_word_type w);
         longint       one;
         longint       mean;
         longint       scaled;
         q_value_type  cov[DPF_CHANNELS];
         q_value_type  colour_in[DPF_CHANNELS];
         q_value_type  alpha_in[DPF_CHANNELS];
         q_value_type  depth_in[DPF_DEPTHS];
         rsp_word_type px;
         one = longint'(1) << DPF_FRAC_BITS;
         if (w.empty_pixel) begin
            px = '0;
            px.out_depth_front = DPF_Q_MAX;
            px.out_depth_back  = DPF_Q_MAX;
            owed_pixels.push_back(px);
            clear_pixel();
            return;
         end
         colour_in = '{w.red, w.green, w.blue};
         alpha_in  = '{w.alpha_red, w.alpha_green, w.alpha_blue};
         depth_in  = '{w.depth_front, w.depth_back};
         cov = alpha_acc;
         mean = (longint'(cov[0]) + longint'(cov[1]) + longint'(cov[2])) / 3;
         if (mean < one) begin
            foreach (colour_acc[i])
               colour_acc[i] = clamp(longint'(colour_acc[i]) +
                                     rescale((one - longint'(cov[i])) * longint'(colour_in[i])));
            foreach (alpha_acc[i])
               alpha_acc[i] = clamp(longint'(alpha_acc[i]) +
                                    rescale((one - mean) * longint'(alpha_in[i])));
            foreach (depth_acc[i]) begin
               scaled = longint'(clamp(rescale(longint'(depth_acc[i]) * mean)));
               depth_acc[i] = clamp(scaled + rescale((one - mean) * longint'(depth_in[i])));
            end
         end
         if (w.last_sample) begin
            px.out_red         = colour_acc[0];
            px.out_green       = colour_acc[1];
            px.out_blue        = colour_acc[2];
            px.out_alpha_red   = alpha_acc[0];
            px.out_alpha_green = alpha_acc[1];
            px.out_alpha_blue  = alpha_acc[2];
            px.out_depth_front = depth_acc[0];
            px.out_depth_back  = depth_acc[1];
            owed_pixels.push_back(px);
            clear_pixel();
         end
      endfunction

      function void compare_field(string name, logic [DPF_DATA_W-1:0] want,
                                  logic [DPF_DATA_W-1:0] got);
         if (got !== want) begin
            $error("%s: expected %h, got %h", name, want, got);
            failures++;
         end
      endfunction

      // check a pixel word taken from the block against the oldest owed one
      function void check_pixel(rsp_word_type got);
         rsp_word_type want;
         if (owed_pixels.size() == 0) begin
            $error("pixel word with none owed: %h", got);
            failures++;
            return;
         end
         want = owed_pixels.pop_front();
         compare_field("out_red", want.out_red, got.out_red);
         compare_field("out_green", want.out_green, got.out_green);
         compare_field("out_blue", want.out_blue, got.out_blue);
         compare_field("out_alpha_red", want.out_alpha_red, got.out_alpha_red);
         compare_field("out_alpha_green", want.out_alpha_green, got.out_alpha_green);
         compare_field("out_alpha_blue", want.out_alpha_blue, got.out_alpha_blue);
         compare_field("out_depth_front", want.out_depth_front, got.out_depth_front);
         compare_field("out_depth_back", want.out_depth_back, got.out_depth_back);
      endfunction
   endclass

   // ------------------------------------------------------------------
   // clock, reset, channels and the block itself
   // ------------------------------------------------------------------
   logic clock = 1'b0;
   logic reset = 1'b1;

   dpf_req_if sample_ch ();
   dpf_rsp_if pixel_ch ();

   deep_pixel_flatten uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (sample_ch),
      .rsp_if (pixel_ch)
   );

   pixel_scoreboard_type scoreboard = new;

   always #(CLOCK_PERIOD / 2) clock = ~clock;

   // ------------------------------------------------------------------
   // receiver: a 16-bit ready pattern rotates and is redrawn each time the phase counter wraps;
   // the draws give runs of full throughput, long stalls and random chatter
   // ------------------------------------------------------------------
   bit [15:0] stall_pattern = '1;
   bit [5:0]  stall_phase   = '0;

   always @(posedge clock) begin
      if (stall_phase == 0) begin
         case ($urandom_range(0, 3))
            0: begin
               stall_pattern <= '1;
            end
            1: begin
               stall_pattern <= 16'h0001;
            end
            default: begin
               stall_pattern <= 16'($urandom);
            end
         endcase
      end else begin
         stall_pattern <= {stall_pattern[0], stall_pattern[15:1]};
      end
      pixel_ch.ready <= stall_pattern[0];
      stall_phase    <= stall_phase + 1'b1;
   end

   // result monitor: every pixel word taken goes to the scoreboard
   always @(posedge clock) begin
      if (!reset && pixel_ch.valid && pixel_ch.ready) begin
         scoreboard.check_pixel(pixel_ch.data);
      end
   end

   // watchdog: counts cycles in which neither channel moves a word
   int idle_cycles = 0;

   always @(posedge clock) begin
      if ((sample_ch.valid && sample_ch.ready) || (pixel_ch.valid && pixel_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("deep_pixel_flatten_tb NOT OK");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ------------------------------------------------------------------
   // stimulus helpers
   // ------------------------------------------------------------------
   int burst_left  = 0;
   int words_sent  = 0;

   function automatic q_value_type pick_extreme();
      case ($urandom_range(0, 6))
         0: return DPF_Q_MAX;
         1: return DPF_Q_MIN;
         2: return '0;
         3: return UNIT_Q;
         4: return -UNIT_Q;
         5: return 1;
         default: return -1;
      endcase
   endfunction

   // colour and depth values: full range, edges, or modest signed values
   function automatic q_value_type rand_value();
      case ($urandom_range(0, 9))
         0, 1, 2: return q_value_type'($urandom);
         3: return pick_extreme();
         default: return q_value_type'(int'($urandom_range(0, 8 * UNIT_Q)) - 4 * UNIT_Q);
      endcase
   endfunction

   // alphas mostly in [0, 1.25] so coverage builds up to opaque within a pixel
   function automatic q_value_type rand_alpha();
      case ($urandom_range(0, 9))
         0: return q_value_type'($urandom);
         1: return pick_extreme();
         default: return q_value_type'($urandom_range(0, UNIT_Q + UNIT_Q / 4));
      endcase
   endfunction

   function automatic req_word_type rand_sample(bit last);
      req_word_type w;
      w.red         = rand_value();
      w.green       = rand_value();
      w.blue        = rand_value();
      w.alpha_red   = rand_alpha();
      w.alpha_green = rand_alpha();
      w.alpha_blue  = rand_alpha();
      w.depth_front = rand_value();
      w.depth_back  = rand_value();
      w.last_sample = last;
      w.empty_pixel = 1'b0;
      return w;
   endfunction

   function automatic req_word_type make_sample(q_value_type colour, q_value_type alpha,
                                                q_value_type depth, bit last, bit empty);
      req_word_type w;
      w.red         = colour;
      w.green       = colour;
      w.blue        = colour;
      w.alpha_red   = alpha;
      w.alpha_green = alpha;
      w.alpha_blue  = alpha;
      w.depth_front = depth;
      w.depth_back  = depth;
      w.last_sample = last;
      w.empty_pixel = empty;
      return w;
   endfunction

   // present one word and hold it until taken; the sender works in bursts,
   // and only drops valid when a gap actually follows
   task automatic send_word(input req_word_type w);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 9) < 3) ? 0 : $urandom_range(1, 12);
         if (gap > 0) begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 30);
      end
      sample_ch.valid <= 1'b1;
      sample_ch.data  <= w;
      do @(posedge clock); while (!sample_ch.ready);
      scoreboard.note_sample(w);
      burst_left--;
      words_sent++;
   endtask

   // ------------------------------------------------------------------
   // main sequence
   // ------------------------------------------------------------------
   initial begin
      req_word_type w;
      int           roll;
      int           depth;
      sample_ch.valid = 1'b0;
      sample_ch.data  = '0;
      pixel_ch.ready  = 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;

      // empty pixel, once with last set and once without; data is ignored
      w = rand_sample(1'b1);
      w.empty_pixel = 1'b1;
      send_word(w);
      send_word(make_sample(DPF_Q_MAX, DPF_Q_MIN, -1, 1'b0, 1'b1));
      // single-sample pixels at the field extremes, saturation included
      send_word(make_sample('0, '0, '0, 1'b1, 1'b0));
      send_word(make_sample(DPF_Q_MAX, DPF_Q_MAX, DPF_Q_MAX, 1'b1, 1'b0));
      send_word(make_sample(DPF_Q_MIN, DPF_Q_MIN, DPF_Q_MIN, 1'b1, 1'b0));
      send_word(make_sample(-1, 1, DPF_Q_MIN, 1'b1, 1'b0));
      // opaque front sample: the two behind it change nothing
      send_word(make_sample(UNIT_Q / 2, UNIT_Q, 5 * UNIT_Q, 1'b0, 1'b0));
      send_word(make_sample(DPF_Q_MAX, UNIT_Q, 7 * UNIT_Q, 1'b0, 1'b0));
      send_word(make_sample(DPF_Q_MIN, UNIT_Q / 3, 9 * UNIT_Q, 1'b1, 1'b0));
      // negative coverage drives the factors above one, then large values overflow
      send_word(make_sample(UNIT_Q, DPF_Q_MIN, 2 * UNIT_Q, 1'b0, 1'b0));
      send_word(make_sample(DPF_Q_MAX, DPF_Q_MAX, DPF_Q_MAX, 1'b0, 1'b0));
      send_word(make_sample(DPF_Q_MIN, -UNIT_Q, DPF_Q_MIN, 1'b1, 1'b0));
      // partial pixel thrown away by an empty word, then a clean one
      send_word(make_sample(3 * UNIT_Q, UNIT_Q / 4, 4 * UNIT_Q, 1'b0, 1'b0));
      send_word(make_sample('0, '0, '0, 1'b1, 1'b1));
      send_word(make_sample(UNIT_Q, UNIT_Q / 4, UNIT_Q, 1'b1, 1'b0));
      // a few gradual layers reaching full coverage
      send_word(make_sample(UNIT_Q / 8, UNIT_Q / 3, UNIT_Q, 1'b0, 1'b0));
      send_word(make_sample(UNIT_Q / 8, UNIT_Q / 2, 2 * UNIT_Q, 1'b0, 1'b0));
      send_word(make_sample(UNIT_Q / 8, UNIT_Q, 3 * UNIT_Q, 1'b0, 1'b0));
      send_word(make_sample(UNIT_Q / 8, UNIT_Q, 4 * UNIT_Q, 1'b1, 1'b0));

      // random pixels: mostly short, some deep enough to go opaque, odd empty
      // words and pixels cut short by an empty word
      words_sent = 0;
      while (words_sent < RANDOM_WORDS) begin
         roll = $urandom_range(0, 99);
         if (roll < 5) begin
            w = rand_sample(1'($urandom_range(0, 1)));
            w.empty_pixel = 1'b1;
            send_word(w);
         end else begin
            depth = (roll < 18) ? $urandom_range(7, 24) : $urandom_range(1, 6);
            for (int k = 0; k < depth; k++) begin
               if (k > 0 && $urandom_range(0, 99) < 2) begin
                  w = rand_sample(1'($urandom_range(0, 1)));
                  w.empty_pixel = 1'b1;
                  send_word(w);
                  break;
               end
               send_word(rand_sample(k == depth - 1));
            end
         end
      end
      sample_ch.valid <= 1'b0;

      // let every owed pixel come out, then a few quiet cycles for strays
      while (scoreboard.pending() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (scoreboard.failures == 0 && scoreboard.pending() == 0) begin
         $display("deep_pixel_flatten_tb OK");
      end else begin
         $display("deep_pixel_flatten_tb NOT OK");
      end
      $finish;
   end

endmodule
